/* rtl/tln_pkg.sv */
package tln_pkg;

  localparam int PENDING_DEPTH_DEF = 32;

  localparam logic [7:0] LEAD_BYTE  = 8'hC3;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] FOLD_MASK  = 8'hDF;

  // folded second bytes, upper-case form, ranges per letter
  localparam logic [7:0] FOLD_A_LO = 8'h80;
  localparam logic [7:0] FOLD_A_HI = 8'h85;
  localparam logic [7:0] FOLD_C    = 8'h87;
  localparam logic [7:0] FOLD_E_LO = 8'h88;
  localparam logic [7:0] FOLD_E_HI = 8'h8B;
  localparam logic [7:0] FOLD_I_LO = 8'h8C;
  localparam logic [7:0] FOLD_I_HI = 8'h8F;
  localparam logic [7:0] FOLD_O_LO = 8'h92;
  localparam logic [7:0] FOLD_O_HI = 8'h96;
  localparam logic [7:0] FOLD_U_LO = 8'h99;
  localparam logic [7:0] FOLD_U_HI = 8'h9C;
  localparam logic [7:0] NO_FOLD   = 8'h00;

  // result kinds, in the order they leave for one item
  typedef enum logic [2:0] {
    PH_NONE  = 3'd0,
    PH_FLUSH = 3'd1,
    PH_A     = 3'd2,
    PH_B     = 3'd3,
    PH_C3    = 3'd4,
    PH_MARK  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRD,
    ST_FEM,
    ST_EA,
    ST_EB,
    ST_EC,
    ST_EM
  } state_t;

  typedef struct packed {
    logic flush;
    logic a;
    logic b;
    logic c3;
    logic mark;
  } flags_t;

  typedef struct packed {
    logic   load;
    logic   rd;
    logic   emit;
    phase_t sel;
  } cmd_t;

  typedef struct packed {
    flags_t new_flags;
    flags_t item_flags;
    logic   flush_last;
    logic   slot_free;
  } sts_t;

  function automatic logic [7:0] fold_letter(input logic [7:0] n);
    logic [7:0] k;
    logic [7:0] r;
    k = n & FOLD_MASK;
    r = NO_FOLD;
    if (n[7:6] == 2'b10) begin
      if (k >= FOLD_A_LO && k <= FOLD_A_HI) r = "a";
      else if (k == FOLD_C) r = "c";
      else if (k >= FOLD_E_LO && k <= FOLD_E_HI) r = "e";
      else if (k >= FOLD_I_LO && k <= FOLD_I_HI) r = "i";
      else if (k >= FOLD_O_LO && k <= FOLD_O_HI) r = "o";
      else if (k >= FOLD_U_LO && k <= FOLD_U_HI) r = "u";
    end
    return r;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) r = c + CASE_BIT;
    return r;
  endfunction

  // first result kind after 'from' that this item still has
  function automatic phase_t next_phase(input flags_t f, input phase_t from);
    phase_t r;
    r = PH_NONE;
    if (from < PH_FLUSH && f.flush) r = PH_FLUSH;
    else if (from < PH_A && f.a) r = PH_A;
    else if (from < PH_B && f.b) r = PH_B;
    else if (from < PH_C3 && f.c3) r = PH_C3;
    else if (from < PH_MARK && f.mark) r = PH_MARK;
    return r;
  endfunction

endpackage

/* rtl/text_line_normalizer_unit.sv */
// Streaming text line normalizer. Bytes of one line come in as beats
// (in_byte, byte_present, end_of_line); the normalized line leaves as beats
// (out_byte, out_present, out_last, ws_overflow). Leading and trailing
// spaces/tabs are dropped, space runs shrink to one space, tabs are kept,
// A-Z are lowercased and UTF-8 0xC3 pairs of accented a/c/e/i/o/u fold to
// the plain letter. Whitespace after text waits in a PENDING_DEPTH entry
// store until the next text byte flushes it; past that depth it is dropped
// and ws_overflow is raised for the rest of the line. An end-of-line beat
// that yields no byte gives one bare marker beat with out_present low. An
// input beat is accepted in the idle state; the results it yields are then
// emitted one at a time, each flushed whitespace entry as a store read and
// then an emit, and output stalls hold the emission. The sequencer emits at
// most one result per cycle through a single output register, and the
// pending store has one read port. Input is not taken while an item's
// results are still being emitted, but a finished result may sit in the
// output register while the next beat is accepted.
module text_line_normalizer_unit
  import tln_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       byte_present,
  input  logic       end_of_line,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_present,
  output logic       out_last,
  output logic       ws_overflow
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: picks which result of the current item goes out next
  tln_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // line state, pending store, item capture and output register
  tln_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (in_byte),
    .byte_present (byte_present),
    .end_of_line  (end_of_line),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_present  (out_present),
    .out_last     (out_last),
    .ws_overflow  (ws_overflow)
  );

endmodule

/* rtl/tln_ctrl.sv */
module tln_ctrl
  import tln_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  function automatic state_t phase_state(input phase_t p);
    state_t s;
    case (p)
      PH_FLUSH: s = ST_FRD;
      PH_A:     s = ST_EA;
      PH_B:     s = ST_EB;
      PH_C3:    s = ST_EC;
      PH_MARK:  s = ST_EM;
      default:  s = ST_IDLE;
    endcase
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = phase_state(next_phase(sts.new_flags, PH_NONE));
      end
      ST_FRD: begin
        state_next = ST_FEM;
      end
      ST_FEM: begin
        if (sts.slot_free) begin
          if (sts.flush_last) state_next = phase_state(next_phase(sts.item_flags, PH_FLUSH));
          else state_next = ST_FRD;
        end
      end
      ST_EA: begin
        if (sts.slot_free) state_next = phase_state(next_phase(sts.item_flags, PH_A));
      end
      ST_EB: begin
        if (sts.slot_free) state_next = phase_state(next_phase(sts.item_flags, PH_B));
      end
      ST_EC: begin
        if (sts.slot_free) state_next = phase_state(next_phase(sts.item_flags, PH_C3));
      end
      ST_EM: begin
        if (sts.slot_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd.load = 1'b0;
    cmd.rd   = 1'b0;
    cmd.emit = 1'b0;
    cmd.sel  = PH_NONE;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_FRD: begin
        cmd.rd = 1'b1;
      end
      ST_FEM: begin
        cmd.sel  = PH_FLUSH;
        cmd.emit = sts.slot_free;
      end
      ST_EA: begin
        cmd.sel  = PH_A;
        cmd.emit = sts.slot_free;
      end
      ST_EB: begin
        cmd.sel  = PH_B;
        cmd.emit = sts.slot_free;
      end
      ST_EC: begin
        cmd.sel  = PH_C3;
        cmd.emit = sts.slot_free;
      end
      ST_EM: begin
        cmd.sel  = PH_MARK;
        cmd.emit = sts.slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/tln_datapath.sv */
module tln_datapath
  import tln_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       byte_present,
  input  logic       end_of_line,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_present,
  output logic       out_last,
  output logic       ws_overflow
);

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int IDX_W = $clog2(PENDING_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PENDING_DEPTH);

  // line state
  logic             seen_text;
  logic [CNT_W-1:0] pend_count;
  logic             last_space;
  logic             held;
  logic             ovf;

  // pending whitespace store, 1 = space, 0 = tab
  logic             pend_mem [PENDING_DEPTH];
  logic             rd_data;
  logic [IDX_W-1:0] idx;

  // captured item
  flags_t           item_flags;
  logic [CNT_W-1:0] flush_n;
  logic [7:0]       a_byte;
  logic [7:0]       b_byte;
  logic             item_eol;
  logic             ovf_old;
  logic             ovf_new;

  // decode of the offered item
  logic       is_space;
  logic       is_ws;
  logic       is_text;
  logic [7:0] fold;
  logic       fold_hit;
  logic       held_after;
  logic       store;
  logic       has_room;
  logic       ovf_after;
  flags_t     new_flags;

  always_comb begin
    is_space   = (in_byte == SPACE_BYTE);
    is_ws      = is_space || (in_byte == TAB_BYTE);
    is_text    = byte_present && !is_ws;
    fold       = fold_letter(in_byte);
    fold_hit   = held && is_text && (fold != NO_FOLD);
    held_after = byte_present ? (is_text && !fold_hit && in_byte == LEAD_BYTE) : held;
    store      = byte_present && is_ws && seen_text && !(is_space && last_space);
    has_room   = (pend_count < DEPTH_C);
    ovf_after  = ovf || (store && !has_room);

    new_flags.flush = is_text && (pend_count != '0);
    new_flags.a     = held && byte_present;
    new_flags.b     = is_text && !fold_hit && (in_byte != LEAD_BYTE);
    new_flags.c3    = end_of_line && held_after;
    new_flags.mark  = end_of_line && !(new_flags.flush || new_flags.a ||
                                       new_flags.b || new_flags.c3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_text  <= 1'b0;
      pend_count <= '0;
      last_space <= 1'b0;
      held       <= 1'b0;
      ovf        <= 1'b0;
    end else if (cmd.load) begin
      if (end_of_line) begin
        seen_text  <= 1'b0;
        pend_count <= '0;
        last_space <= 1'b0;
        held       <= 1'b0;
        ovf        <= 1'b0;
      end else begin
        seen_text <= seen_text || is_text;
        held      <= held_after;
        ovf       <= ovf_after;
        if (is_text) begin
          pend_count <= '0;
          last_space <= 1'b0;
        end else if (store && has_room) begin
          pend_count <= pend_count + CNT_W'(1);
          last_space <= is_space;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store && has_room) begin
      pend_mem[pend_count[IDX_W-1:0]] <= is_space;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= pend_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_flags <= new_flags;
      flush_n    <= pend_count;
      a_byte     <= fold_hit ? fold : LEAD_BYTE;
      b_byte     <= to_lower(in_byte);
      item_eol   <= end_of_line;
      ovf_old    <= ovf;
      ovf_new    <= ovf_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.emit && cmd.sel == PH_FLUSH) begin
      idx <= idx + IDX_W'(1);
    end
  end

  assign sts.new_flags  = new_flags;
  assign sts.item_flags = item_flags;
  assign sts.flush_last = (CNT_W'(idx) + CNT_W'(1) == flush_n);
  assign sts.slot_free  = !out_valid || !out_stall;

  // output register
  logic [7:0] emit_byte;
  logic       emit_present;
  logic       emit_ovf;

  always_comb begin
    emit_present = 1'b1;
    emit_ovf     = ovf_new;
    case (cmd.sel)
      PH_FLUSH: emit_byte = rd_data ? SPACE_BYTE : TAB_BYTE;
      PH_A: begin
        emit_byte = a_byte;
        emit_ovf  = ovf_old;
      end
      PH_B:     emit_byte = b_byte;
      PH_C3:    emit_byte = LEAD_BYTE;
      default: begin
        emit_byte    = '0;
        emit_present = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= emit_byte;
      out_present <= emit_present;
      out_last    <= item_eol && (next_phase(item_flags, cmd.sel) == PH_NONE);
      ws_overflow <= emit_ovf;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= DEPTH_C)
    else $error("pending count above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken result");

  a_mark_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_present) |-> out_last)
    else $error("bare marker not last of line");

  a_eol_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && end_of_line) |=> (pend_count == '0 && !held && !ovf))
    else $error("line state kept past end of line");

  a_flush_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.sel == PH_FLUSH) |-> item_flags.flush)
    else $error("flush result without pending whitespace");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

import tln_pkg::*;

// Line normalizer scoreboard: keeps its own copy of the per-line state,
// turns every accepted input beat into the output beats it must produce,
// and checks output beats against them in order.
class norm_line_checker;
  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       last;
    logic       ovf;
  } norm_beat_t;

  bit         text_seen;
  bit         ws_kind [tln_pkg::PENDING_DEPTH_DEF];  // 1 = space, 0 = tab
  int         ws_held;
  bit         tail_is_space;
  bit         lead_waiting;
  bit         ws_cut;
  norm_beat_t item_out[$];
  norm_beat_t norm_beats_due[$];
  int         mismatches;
  int         beats_checked;

  // plain letter for the second byte of an accented 0xC3 pair, 0 if none
  function logic [7:0] accent_base(logic [7:0] n);
    if (n[7:6] != 2'b10) return 8'h00;
    case (n[4:0])
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: return "a";
      5'd7: return "c";
      5'd8, 5'd9, 5'd10, 5'd11: return "e";
      5'd12, 5'd13, 5'd14, 5'd15: return "i";
      5'd18, 5'd19, 5'd20, 5'd21, 5'd22: return "o";
      5'd25, 5'd26, 5'd27, 5'd28: return "u";
      default: return 8'h00;
    endcase
  endfunction

  function logic [7:0] lowered(logic [7:0] c);
    if (c >= "A" && c <= "Z") return c | 8'h20;
    return c;
  endfunction

  function void add_out(logic [7:0] c, logic p);
    norm_beat_t nb;
    nb.ch      = c;
    nb.present = p;
    nb.last    = 1'b0;
    nb.ovf     = ws_cut;
    item_out.push_back(nb);
  endfunction

  function void take_in_beat(logic [7:0] b, logic present, logic eol);
    norm_beat_t nb;
    logic [7:0] letter;
    bit         is_space;
    int         i;
    item_out.delete();
    if (present) begin
      if (b == SPACE_BYTE || b == TAB_BYTE) begin
        is_space = (b == SPACE_BYTE);
        if (lead_waiting) begin
          add_out(LEAD_BYTE, 1'b1);
          lead_waiting = 0;
        end
        // space right after a stored space collapses; leading ws is dropped
        if (text_seen && !(is_space && tail_is_space)) begin
          if (ws_held >= tln_pkg::PENDING_DEPTH_DEF) begin
            ws_cut = 1;
          end else begin
            ws_kind[ws_held] = is_space;
            ws_held++;
            tail_is_space = is_space;
          end
        end
      end else begin
        for (i = 0; i < ws_held; i++)
          add_out(ws_kind[i] ? SPACE_BYTE : TAB_BYTE, 1'b1);
        ws_held       = 0;
        tail_is_space = 0;
        text_seen     = 1;
        letter        = 8'h00;
        if (lead_waiting) begin
          lead_waiting = 0;
          letter = accent_base(b);
          if (letter == 8'h00) add_out(LEAD_BYTE, 1'b1);
        end
        if (letter != 8'h00) add_out(letter, 1'b1);
        else if (b == LEAD_BYTE) lead_waiting = 1;
        else add_out(lowered(b), 1'b1);
      end
    end
    if (eol) begin
      if (lead_waiting) add_out(LEAD_BYTE, 1'b1);
      if (item_out.size() == 0) add_out(8'h00, 1'b0);
      text_seen     = 0;
      ws_held       = 0;
      tail_is_space = 0;
      lead_waiting  = 0;
      ws_cut        = 0;
    end
    for (i = 0; i < item_out.size(); i++) begin
      nb      = item_out[i];
      nb.last = eol && (i == item_out.size() - 1);
      norm_beats_due.push_back(nb);
    end
  endfunction

  function void check_out_beat(logic [7:0] ch, logic present, logic last, logic ovf);
    norm_beat_t want;
    beats_checked++;
    if (norm_beats_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("out beat %0d unexpected: byte %h present %b last %b ovf %b",
                 beats_checked, ch, present, last, ovf);
    end else begin
      want = norm_beats_due.pop_front();
      if (want.ch !== ch || want.present !== present || want.last !== last ||
          want.ovf !== ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("out beat %0d: want byte %h present %b last %b ovf %b, %s %h %b %b %b",
                   beats_checked, want.ch, want.present, want.last, want.ovf,
                   "got", ch, present, last, ovf);
      end
    end
  endfunction

  function int due_count();
    return norm_beats_due.size();
  endfunction
endclass

module tb_top;
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       byte_present = 1'b0;
  logic       end_of_line = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_present;
  logic       out_last;
  logic       ws_overflow;

  norm_line_checker line_sb = new;

  int src_idle_pct = 0;   // chance per beat of a sender gap
  int stall_pct    = 0;   // chance per cycle of a receiver stall
  int hold_left    = 0;   // cycles left in a forced receiver hold-off
  int beats_sent   = 0;   // beats that carry a byte or end a line

  text_line_normalizer_unit dut (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .in_byte,
    .byte_present,
    .end_of_line,
    .out_valid,
    .out_stall,
    .out_byte,
    .out_present,
    .out_last,
    .ws_overflow
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs; the slowest legal run is far shorter.
  initial begin
    #4ms;
    $display("text_line_normalizer_unit verification failed");
    $finish;
  end

  // Receiver: random stalls, or a forced hold-off counted down here so the
  // block backs up into its input while the sender keeps offering beats.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Inputs and outputs only move at the rising edge, so at the falling edge
  // everything is settled; a handshake seen here completes at the next edge.
  // Outputs are checked before the new input is noted so that a spurious
  // output beat can never borrow the expectation of a beat still going in.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        line_sb.check_out_beat(out_byte, out_present, out_last, ws_overflow);
      if (in_valid && !in_stall)
        line_sb.take_in_beat(in_byte, byte_present, end_of_line);
    end
  end

  // Offer one beat, after an optional random gap, and return at the edge
  // that takes it. Valid is never dropped and raised in the same step.
  task automatic send_beat(input logic [7:0] b, input logic p, input logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    byte_present <= p;
    end_of_line  <= e;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (p || e) beats_sent++;
  endtask

  task automatic send_text(input logic [7:0] b);
    send_beat(b, 1'b1, 1'b0);
  endtask

  function automatic logic [7:0] any_letter();
    logic [7:0] c;
    c = "A" + 8'($urandom_range(25));
    if ($urandom_range(1)) c = c | 8'h20;
    return c;
  endfunction

  // One line: mostly letters with whitespace runs and accent pairs, some
  // raw bytes and bare beats; now and then a whitespace run long enough that it
  // can spill the pending store.
  task automatic send_random_line();
    int         body;
    int         pick;
    logic [7:0] b;
    if ($urandom_range(9) == 0) begin
      send_text(any_letter());
      body = $urandom_range(34, 48);
      repeat (body) send_text(($urandom_range(99) < 60) ? TAB_BYTE : SPACE_BYTE);
    end
    body = $urandom_range(0, 9);
    repeat (body) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_text(any_letter());
      end else if (pick < 50) begin
        send_text(SPACE_BYTE);
      end else if (pick < 60) begin
        send_text(TAB_BYTE);
      end else if (pick < 72) begin
        send_text(LEAD_BYTE);
        if ($urandom_range(99) < 70) send_text(8'($urandom_range(8'h80, 8'hBF)));
        else send_text(8'($urandom_range(255)));
      end else if (pick < 86) begin
        send_text(8'($urandom_range(255)));
      end else if (pick < 92) begin
        send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      end else begin
        send_text(LEAD_BYTE);
      end
    end
    // closing beat of the line
    pick = $urandom_range(99);
    if (pick < 40) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
    else if (pick < 55) send_beat($urandom_range(1) ? SPACE_BYTE : TAB_BYTE, 1'b1, 1'b1);
    else if (pick < 65) send_beat(LEAD_BYTE, 1'b1, 1'b1);
    else if (pick < 85) send_beat(any_letter(), 1'b1, 1'b1);
    else send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
  endtask

  initial begin
    int ph;
    int goal;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // leading ws dropped, space run collapses, tab kept between spaces,
    // line ends in whitespace so only a bare end marker closes it
    send_text(SPACE_BYTE);
    send_text(TAB_BYTE);
    send_text("A");
    send_text(SPACE_BYTE);
    send_text(SPACE_BYTE);
    send_text(TAB_BYTE);
    send_text(SPACE_BYTE);
    send_text("z");
    send_beat(TAB_BYTE, 1'b1, 1'b1);

    // accent pairs: upper and lower case folds, lead byte followed by a
    // non-fold letter, by whitespace, by another lead byte, held at the end
    send_text(LEAD_BYTE);
    send_text(8'h87);
    send_text(LEAD_BYTE);
    send_text(8'hA9);
    send_text(LEAD_BYTE);
    send_text("X");
    send_text(LEAD_BYTE);
    send_text(SPACE_BYTE);
    send_text("Q");
    send_text(LEAD_BYTE);
    send_text(LEAD_BYTE);
    send_text(8'hFF);
    send_text(8'h00);
    send_beat(LEAD_BYTE, 1'b1, 1'b1);

    // bare beat inside a line does nothing; bare end gives an empty line
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          stall_pct    = 0;
          hold_left    = 160;
        end
        1: begin
          src_idle_pct = 61;
          stall_pct    = 0;
        end
        2: begin
          src_idle_pct = 0;
          stall_pct    = 61;
        end
        default: begin
          src_idle_pct = 8;
          stall_pct    = 8;
        end
      endcase
      goal = beats_sent + 50;
      while (beats_sent < goal) send_random_line();
    end
    in_valid <= 1'b0;

    // drain, then give the block time to show any stray beat
    while (line_sb.due_count() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (line_sb.due_count() != 0)
      $display("%0d output beats never arrived", line_sb.due_count());
    if (line_sb.mismatches == 0 && line_sb.due_count() == 0) begin
      $display("text_line_normalizer_unit verification clean");
    end else begin
      $display("text_line_normalizer_unit verification failed");
    end
    $finish;
  end
endmodule
